/* rtl/nwhe_pkg.sv */
`default_nettype none
package nwhe_pkg;

  localparam int MaxWaypoints = 256;
  localparam int AddrW        = $clog2(MaxWaypoints);
  localparam int CountW       = 9;
  localparam int DistW        = 65;

  localparam logic CmdLoad  = 1'b0;
  localparam logic CmdQuery = 1'b1;

  localparam logic RegWaypointCount = 1'b0;

  // one table entry as stored in the waypoint memory
  typedef struct packed {
    logic signed [31:0] lat;
    logic signed [31:0] lon;
    logic signed [15:0] spd;
    logic        [15:0] hdg;
  } wp_entry_t;

  // sideband that travels with an entry through the distance pipeline
  typedef struct packed {
    logic [7:0]         idx;
    logic signed [15:0] spd;
    logic        [15:0] hdg;
  } wp_tag_t;

  // shortest turn from real to target, left negative, half turn positive
  function automatic logic signed [16:0] heading_err(input logic [15:0] target,
                                                     input logic [15:0] real_hdg);
    logic [15:0] d;
    logic [16:0] r;
    d = target - real_hdg;
    if (d == 16'd0) begin
      r = 17'd0;
    end else if (!d[15]) begin
      r = 17'd0 - {1'b0, d};
    end else begin
      r = 17'h10000 - {1'b0, d};
    end
    return signed'(r);
  endfunction

endpackage
`default_nettype wire

/* rtl/nwhe_dist.sv */
`default_nettype none
module nwhe_dist (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  vld_i,
  input  wire nwhe_pkg::wp_entry_t   entry_i,
  input  wire nwhe_pkg::wp_tag_t     tag_i,
  input  wire logic signed [30:0]    qlat_i,
  input  wire logic signed [31:0]    qlon_i,
  output logic                       vld_o,
  output logic [nwhe_pkg::DistW-1:0] dist_o,
  output nwhe_pkg::wp_tag_t          tag_o,
  output logic                       busy_o
);
  import nwhe_pkg::*;

  logic [2:0]         vld_q;
  logic [31:0]        dl_q, dn_q;
  logic [63:0]        sa_q, sb_q;
  logic [DistW-1:0]   dist_q;
  wp_tag_t            tag_a_q, tag_b_q, tag_c_q;

  logic signed [32:0] diff_lat, diff_lon;
  logic [32:0]        abs_lat, abs_lon;

  always_comb begin
    diff_lat = {entry_i.lat[31], entry_i.lat} - {{2{qlat_i[30]}}, qlat_i};
    diff_lon = {entry_i.lon[31], entry_i.lon} - {qlon_i[31], qlon_i};
    abs_lat  = diff_lat[32] ? 33'(-diff_lat) : 33'(diff_lat);
    abs_lon  = diff_lon[32] ? 33'(-diff_lon) : 33'(diff_lon);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], vld_i};
    end
  end

  // magnitudes, then squares, then the exact 65-bit sum
  always_ff @(posedge clk_i) begin
    dl_q    <= abs_lat[31:0];
    dn_q    <= abs_lon[31:0];
    tag_a_q <= tag_i;
    sa_q    <= dl_q * dl_q;
    sb_q    <= dn_q * dn_q;
    tag_b_q <= tag_a_q;
    dist_q  <= {1'b0, sa_q} + {1'b0, sb_q};
    tag_c_q <= tag_b_q;
  end

  assign vld_o  = vld_q[2];
  assign dist_o = dist_q;
  assign tag_o  = tag_c_q;
  assign busy_o = |vld_q;

endmodule
`default_nettype wire

/* rtl/nearest_waypoint_heading_error.sv */
`default_nettype none
// Channel   Direction  Handshake                    Payload
// s_axis    in         s_axis_tvalid/s_axis_tready  load or query item
// m_axis    out        m_axis_tvalid/m_axis_tready  nearest slot, heading error, speed
// apb       in         psel/penable/pwrite/pready   waypoint_count at address 0
//
// A load gives no result. A query scans n table entries, n being
// waypoint_count held to 1..256: one shared distance pipeline sees one table entry
// per cycle from the single memory read port, and the running minimum is kept after it.
// rst_ni clears control and sets waypoint_count to 1; the table is not cleared.
// The input is ready only while idle; a finished result waits in the output
// register and a newer query holds at its end until that result is taken.
module nearest_waypoint_heading_error (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // entry_index[7:0], latitude[38:8], longitude[70:39], speed_value[86:71],
  // heading[102:87], zero pad[103]
  input  wire logic [103:0] s_axis_tdata,
  // command[0]
  input  wire logic [0:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // nearest_index[7:0], turn_err[24:8], wp_speed[40:25], zero pad[47:41]
  output logic [47:0]       m_axis_tdata,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import nwhe_pkg::*;

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StScan  = 2'd1;
  localparam logic [1:0] StDrain = 2'd2;
  localparam logic [1:0] StOut   = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [CountW-1:0]  wc_q;
  logic [AddrW-1:0]   cnt_q, lim_q, lim_d;
  logic signed [30:0] qlat_q;
  logic signed [31:0] qlon_q;
  logic [15:0]        qhdg_q;

  wp_entry_t          mem [MaxWaypoints];
  wp_entry_t          rd_data_q, wr_entry;
  logic [AddrW-1:0]   rd_idx_q;
  logic               rd_vld_q;
  logic               in_acc, wr_en, rd_en;

  logic               dist_vld, dist_busy;
  logic [DistW-1:0]   cand_dist;
  wp_tag_t            dist_tag, rd_tag;
  logic [DistW-1:0]   best_dist_q;
  wp_tag_t            best_tag_q;

  logic               out_vld_q;
  logic [47:0]        out_data_q;
  logic               out_load;

  assign pready = 1'b1;

  always_comb begin
    prdata = '0;
    if (paddr[2] == RegWaypointCount) begin
      prdata = 32'(wc_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wc_q <= CountW'(1);
    end else if (psel && penable && pwrite && paddr[2] == RegWaypointCount) begin
      wc_q <= pwdata[CountW-1:0];
    end
  end

  assign s_axis_tready = (state_q == StIdle);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign wr_en         = in_acc && s_axis_tuser[0] == CmdLoad
                         && int'(s_axis_tdata[7:0]) < MaxWaypoints;
  assign rd_en         = (state_q == StScan);
  assign out_load      = (state_q == StOut) && (!out_vld_q || m_axis_tready);

  always_comb begin
    wr_entry.lat = {s_axis_tdata[38], s_axis_tdata[38:8]};
    wr_entry.lon = s_axis_tdata[70:39];
    wr_entry.spd = s_axis_tdata[86:71];
    wr_entry.hdg = s_axis_tdata[102:87];
  end

  // search limit: a count of zero acts as one, above the table size as the table size
  always_comb begin
    if (wc_q == '0) begin
      lim_d = '0;
    end else if (int'(wc_q) > MaxWaypoints) begin
      lim_d = AddrW'(MaxWaypoints - 1);
    end else begin
      lim_d = AddrW'(wc_q - CountW'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[AddrW'(s_axis_tdata[7:0])] <= wr_entry;
    end
    if (rd_en) begin
      rd_data_q <= mem[cnt_q];
      rd_idx_q  <= cnt_q;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_acc && s_axis_tuser[0] == CmdQuery) begin
          state_d = StScan;
        end
      end
      StScan: begin
        if (cnt_q == lim_q) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        if (!rd_vld_q && !dist_busy) begin
          state_d = StOut;
        end
      end
      StOut: begin
        if (out_load) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      rd_vld_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= rd_en;
      if (in_acc) begin
        cnt_q <= '0;
      end else if (rd_en) begin
        cnt_q <= cnt_q + AddrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && s_axis_tuser[0] == CmdQuery) begin
      qlat_q <= s_axis_tdata[38:8];
      qlon_q <= s_axis_tdata[70:39];
      qhdg_q <= s_axis_tdata[102:87];
      lim_q  <= lim_d;
    end
  end

  always_comb begin
    rd_tag.idx = 8'(rd_idx_q);
    rd_tag.spd = rd_data_q.spd;
    rd_tag.hdg = rd_data_q.hdg;
  end

  nwhe_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (rd_vld_q),
    .entry_i (rd_data_q),
    .tag_i   (rd_tag),
    .qlat_i  (qlat_q),
    .qlon_i  (qlon_q),
    .vld_o   (dist_vld),
    .dist_o  (cand_dist),
    .tag_o   (dist_tag),
    .busy_o  (dist_busy)
  );

  // take slot 0 unconditionally; later slots only when strictly nearer
  always_ff @(posedge clk_i) begin
    if (dist_vld && (dist_tag.idx == 8'd0 || cand_dist < best_dist_q)) begin
      best_dist_q <= cand_dist;
      best_tag_q  <= dist_tag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= {7'd0, best_tag_q.spd, heading_err(best_tag_q.hdg, qhdg_q),
                     best_tag_q.idx};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule
`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
module testbench;
  import nwhe_pkg::*;

  typedef struct packed {
    logic               cmd;
    logic [7:0]         slot;
    logic signed [30:0] lat;
    logic signed [31:0] lon;
    logic signed [15:0] spd;
    logic [15:0]        hdg;
  } nav_beat_t;

  typedef struct packed {
    logic [7:0]         idx;
    logic signed [16:0] herr;
    logic signed [15:0] spd;
  } steer_t;

  localparam int RegSpare      = 1;
  localparam int ItemsPerPhase = 75;
  localparam int DrainCycles   = 16;
  localparam int CycleLimit    = 2_500_000;
  localparam int LatLo         = -(2 ** 30);
  localparam int LatHi         = 2 ** 30 - 1;
  localparam int LonLo         = int'(32'h8000_0000);
  localparam int LonHi         = int'(32'h7FFF_FFFF);

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  wire          s_axis_tready;
  logic [103:0] s_axis_tdata  = '0;
  logic [0:0]   s_axis_tuser  = '0;
  wire          m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  wire  [47:0]  m_axis_tdata;
  logic         psel          = 1'b0;
  logic         penable       = 1'b0;
  logic         pwrite        = 1'b0;
  logic [2:0]   paddr         = '0;
  logic [31:0]  pwdata        = '0;
  wire  [31:0]  prdata;
  wire          pready;

  nearest_waypoint_heading_error i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  // predictor state
  wp_entry_t         nav_table [MaxWaypoints];
  logic [CountW-1:0] search_count = CountW'(1);
  steer_t            expected_steer [$];

  // stimulus side mirror of the table, used to aim queries and loads
  nav_beat_t pending_beats [$];
  nav_beat_t beat_on_bus;
  int        plan_lat [MaxWaypoints];
  int        plan_lon [MaxWaypoints];
  int        plan_hdg [MaxWaypoints];
  int        plan_span = 1;
  int        cen_lat = 0;
  int        cen_lon = 0;

  int          n_errors      = 0;
  int          send_idle_pct = 38;
  int          recv_idle_pct = 87;
  int unsigned cycle_count   = 0;
  steer_t      seen_steer;
  steer_t      due_steer;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [66:0] dist_sq(input wp_entry_t e, input logic signed [30:0] qlat,
                                           input logic signed [31:0] qlon);
    logic signed [32:0] dl, dn;
    logic [66:0]        ml, mn;
    dl = {e.lat[31], e.lat} - {{2{qlat[30]}}, qlat};
    dn = {e.lon[31], e.lon} - {qlon[31], qlon};
    ml = dl[32] ? 67'(-dl) : 67'(dl);
    mn = dn[32] ? 67'(-dn) : 67'(dn);
    return ml * ml + mn * mn;
  endfunction

  // load writes the table; query scans it and queues the expected steering result
  task automatic predict_beat(input nav_beat_t b);
    int          span, best, diff;
    logic [66:0] best_d, d;
    steer_t      s;
    if (b.cmd == CmdLoad) begin
      nav_table[b.slot] = '{lat: {b.lat[30], b.lat}, lon: b.lon, spd: b.spd, hdg: b.hdg};
    end else begin
      span = (search_count == 0) ? 1 :
             (search_count > MaxWaypoints) ? MaxWaypoints : int'(search_count);
      best = 0;
      best_d = dist_sq(nav_table[0], b.lat, b.lon);
      for (int k = 1; k < span; k++) begin
        d = dist_sq(nav_table[k], b.lat, b.lon);
        if (d < best_d) begin
          best_d = d;
          best = k;
        end
      end
      diff = (int'(nav_table[best].hdg) - int'(b.hdg)) & 32'hFFFF;
      if (diff == 0) begin
        s.herr = '0;
      end else if (diff < 32768) begin
        s.herr = 17'(-diff);
      end else begin
        s.herr = 17'(65536 - diff);
      end
      s.idx = 8'(best);
      s.spd = nav_table[best].spd;
      expected_steer = {expected_steer, s};
    end
  endtask

  task automatic push_load(input int slot, input int lat, input int lon, input int spd,
                           input int hdg);
    nav_beat_t b;
    b.cmd = CmdLoad;
    b.slot = 8'(slot);
    b.lat = 31'(lat);
    b.lon = 32'(lon);
    b.spd = 16'(spd);
    b.hdg = 16'(hdg);
    pending_beats = {pending_beats, b};
    plan_lat[b.slot] = b.lat;
    plan_lon[b.slot] = b.lon;
    plan_hdg[b.slot] = int'(b.hdg);
  endtask

  task automatic push_query(input int lat, input int lon, input int hdg);
    nav_beat_t b;
    b.cmd = CmdQuery;
    b.slot = 8'($urandom_range(0, 255));
    b.lat = 31'(lat);
    b.lon = 32'(lon);
    b.spd = 16'($urandom());
    b.hdg = 16'(hdg);
    pending_beats = {pending_beats, b};
  endtask

  function automatic int pick_lat();
    logic signed [30:0] r;
    r = 31'($urandom());
    case ($urandom_range(0, 5))
      0: return LatLo;
      1: return LatHi;
      2: return $urandom_range(0, 1) ? 900_000_000 : -900_000_000;
      default: return r;
    endcase
  endfunction

  function automatic int pick_lon();
    logic signed [31:0] r;
    r = 32'($urandom());
    case ($urandom_range(0, 5))
      0: return LonLo;
      1: return LonHi;
      2: return $urandom_range(0, 1) ? 1_800_000_000 : -1_800_000_000;
      default: return r;
    endcase
  endfunction

  // aim near a stored heading (equal, half turn, one step off) or anywhere
  function automatic int pick_hdg();
    int offs [6];
    offs = '{0, 32768, 1, 65535, 32767, 32769};
    if ($urandom_range(0, 9) < 4) begin
      return (plan_hdg[$urandom_range(0, plan_span - 1)] + offs[$urandom_range(0, 5)]) & 32'hFFFF;
    end
    return int'($urandom_range(0, 65535));
  endfunction

  task automatic add_random_load(input int slot);
    int k, spd;
    k = $urandom_range(0, plan_span - 1);
    spd = int'($urandom_range(0, 65535));
    case ($urandom_range(0, 6))
      // same spot as a searched entry: exact distance ties
      0: push_load(slot, plan_lat[k], plan_lon[k], spd, pick_hdg());
      1, 2, 3: push_load(slot, cen_lat + int'($urandom_range(0, 4000)) - 2000,
                         cen_lon + int'($urandom_range(0, 4000)) - 2000, spd, pick_hdg());
      default: push_load(slot, pick_lat(), pick_lon(), spd, pick_hdg());
    endcase
  endtask

  task automatic add_random_query();
    int k;
    k = $urandom_range(0, plan_span - 1);
    case ($urandom_range(0, 9))
      0, 1, 2: push_query(plan_lat[k] + int'($urandom_range(0, 2)) - 1,
                          plan_lon[k] + int'($urandom_range(0, 2)) - 1, pick_hdg());
      3, 4, 5, 6: push_query(cen_lat + int'($urandom_range(0, 4000)) - 2000,
                             cen_lon + int'($urandom_range(0, 4000)) - 2000, pick_hdg());
      default: push_query(pick_lat(), pick_lon(), pick_hdg());
    endcase
  endtask

  // write one register, then read the count back
  task automatic write_reg(input int index, input int value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(index * 4);
    pwdata  <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (index == int'(RegWaypointCount)) begin
      search_count = CountW'(value);
      plan_span = (search_count == 0) ? 1 :
                  (search_count > MaxWaypoints) ? MaxWaypoints : int'(search_count);
    end
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= 3'(int'(RegWaypointCount) * 4);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== 32'(search_count)) begin
      $display("%0t: waypoint_count read expected %0d got %0d", $time, search_count, prdata);
      n_errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // wait until the block is idle and nothing is owed, then let a load settle
  task automatic drain();
    do @(negedge clk_i);
    while (pending_beats.size() != 0 || s_axis_tvalid || expected_steer.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_beat(beat_on_bus);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          beat_on_bus = pending_beats.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {1'b0, beat_on_bus.hdg, beat_on_bus.spd, beat_on_bus.lon,
                            beat_on_bus.lat, beat_on_bus.slot};
          s_axis_tuser  <= beat_on_bus.cmd;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen_steer.idx  = m_axis_tdata[7:0];
        seen_steer.herr = m_axis_tdata[24:8];
        seen_steer.spd  = m_axis_tdata[40:25];
        if (expected_steer.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, m_axis_tdata);
          n_errors++;
        end else begin
          due_steer = expected_steer.pop_front();
          if (seen_steer.idx !== due_steer.idx || seen_steer.herr !== due_steer.herr ||
              seen_steer.spd !== due_steer.spd) begin
            $display("%0t: expected idx %0d err %0d spd %0d, got idx %0d err %0d spd %0d",
                     $time, due_steer.idx, due_steer.herr, due_steer.spd,
                     seen_steer.idx, seen_steer.herr, seen_steer.spd);
            n_errors++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int phase_counts [16];
    int cnt;
    phase_counts = '{256, 511, 3, 0, 1, 300, 0, 0, 0, 0, 0, 0, 0, 0, 255, 257};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset count of one: extremes and every wrap of the heading error
    push_load(0, 900_000_000, -1_800_000_000, -32768, 0);
    push_query(-900_000_000, 1_800_000_000, 0);
    push_query(LatLo, LonHi, 32768);
    push_query(LatHi, LonLo, 1);
    push_query(0, 0, 65535);
    push_query(0, 0, 32767);
    push_query(0, 0, 32769);
    push_load(255, LatLo, LonLo, 32767, 65535);
    push_load(1, 900_000_000, -1_800_000_000, 7, 40000);
    drain();

    // tie goes to the lower slot; far corner overflows 64 bits and must lose
    write_reg(int'(RegWaypointCount), 2);
    push_query(900_000_000, -1_800_000_000, 40000);
    push_load(0, LatLo, LonLo, 1, 100);
    push_load(1, 0, 0, 2, 200);
    push_query(LatHi, LonHi, 300);
    push_query(LatLo, LonLo, 100);
    drain();

    // count of zero searches slot 0 only; the spare register changes nothing
    write_reg(int'(RegWaypointCount), 0);
    push_query(0, 0, 5);
    drain();
    write_reg(RegSpare, 7);
    push_query(1, 1, 60000);
    drain();

    // fill the whole table while querying the first two slots
    write_reg(int'(RegWaypointCount), 2);
    cen_lat = int'($urandom_range(0, 1_800_000_000)) - 900_000_000;
    cen_lon = int'($urandom_range(0, 1_800_000_000)) * 2 - 1_800_000_000;
    for (int slot = 0; slot < MaxWaypoints; slot++) begin
      add_random_load(slot);
      if ($urandom_range(0, 1)) add_random_query();
    end
    drain();

    for (int p = 0; p < 16; p++) begin
      cnt = phase_counts[p];
      if (p >= 6 && p < 12) begin
        cnt = $urandom_range(2, 16);
      end else if (p >= 12 && p < 14) begin
        cnt = $urandom_range(17, 100);
      end
      if (p == 5) begin
        send_idle_pct = 87;
        recv_idle_pct = 38;
      end else if (p == 11) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      cen_lat = int'($urandom_range(0, 1_800_000_000)) - 900_000_000;
      cen_lon = int'($urandom_range(0, 1_800_000_000)) * 2 - 1_800_000_000;
      // junk in the upper data bits must not reach the count
      write_reg(int'(RegWaypointCount),
                cnt | ($urandom_range(0, 1) ? int'($urandom() & 32'hFFFF_FE00) : 0));
      for (int n = 0; n < ItemsPerPhase; n++) begin
        if ($urandom_range(0, 1)) begin
          add_random_load(($urandom_range(0, 3) != 0) ? $urandom_range(0, plan_span - 1)
                                                      : $urandom_range(0, MaxWaypoints - 1));
        end else begin
          add_random_query();
        end
      end
      drain();
    end

    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
